[hw/rtl/weight_rate_stall_detector_core_defines.svh]
// assertion macros used by the checker file
`ifndef WEIGHT_RATE_STALL_DETECTOR_CORE_DEFINES_SVH
`define WEIGHT_RATE_STALL_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define WRSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrsd assertion failed");

// next-cycle implication, held off during reset
`define WRSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrsd assertion failed");

`endif

[hw/rtl/wrsd_pkg.sv]
package wrsd_pkg;

  localparam int WEIGHT_FRAC = 8;
  localparam int MAX_SHIFT   = 8;
  localparam int RATE_MULT   = 1000;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  localparam logic [3:0]  AVG_SHIFT_RESET   = 4'd3;
  localparam logic [15:0] INTERVAL_RESET    = 16'd100;
  localparam logic [15:0] ALPHA_FAST_RESET  = 16'd16384;
  localparam logic [15:0] ALPHA_SLOW_RESET  = 16'd3277;
  localparam logic [15:0] BETA_VAR_RESET    = 16'd3277;
  localparam logic [15:0] STD_MOVE_RESET    = 16'd768;
  localparam logic [7:0]  BREACH_LIM_RESET  = 8'd5;
  localparam logic [47:0] VAR_RESET         = 48'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVG_SHIFT    = 3'd0,
    REG_INTERVAL     = 3'd1,
    REG_ALPHA_FAST   = 3'd2,
    REG_ALPHA_SLOW   = 3'd3,
    REG_BETA_VAR     = 3'd4,
    REG_STD_MOVE     = 3'd5,
    REG_BREACH_LIMIT = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_EVAL, OP_DIFF, OP_DIVCHK, OP_DIV, OP_SEED,
    OP_B0, OP_B1, OP_B2, OP_B3, OP_B4, OP_GAP, OP_V0, OP_V1, OP_V2,
    OP_T0, OP_T1, OP_T2, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic rate_go;
    logic seeded;
    logic sat;
    logic div_last;
  } dp_status_t;

endpackage

[hw/rtl/wrsd_ctrl.sv]
module wrsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wrsd_pkg::dp_status_t st,
  output wrsd_pkg::dp_cmd_t    cmd
);
  import wrsd_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE   = 19'd1,
    S_EVAL   = 19'd2,
    S_DIFF   = 19'd4,
    S_DIVCHK = 19'd8,
    S_DIV    = 19'd16,
    S_SEED   = 19'd32,
    S_B0     = 19'd64,
    S_B1     = 19'd128,
    S_B2     = 19'd256,
    S_B3     = 19'd512,
    S_B4     = 19'd1024,
    S_GAP    = 19'd2048,
    S_V0     = 19'd4096,
    S_V1     = 19'd8192,
    S_V2     = 19'd16384,
    S_T0     = 19'd32768,
    S_T1     = 19'd65536,
    S_T2     = 19'd131072,
    S_DONE   = 19'd262144
  } state_t;

  state_t state, state_next;
  logic   out_load;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op     = OP_EVAL;
        state_next = st.rate_go ? S_DIFF : S_DONE;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_DIVCHK;
      end
      S_DIVCHK: begin
        cmd.op = OP_DIVCHK;
        if (st.sat) state_next = st.seeded ? S_B0 : S_SEED;
        else state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (st.div_last) state_next = st.seeded ? S_B0 : S_SEED;
      end
      S_SEED: begin cmd.op = OP_SEED; state_next = S_GAP; end
      S_B0:   begin cmd.op = OP_B0;   state_next = S_B1;  end
      S_B1:   begin cmd.op = OP_B1;   state_next = S_B2;  end
      S_B2:   begin cmd.op = OP_B2;   state_next = S_B3;  end
      S_B3:   begin cmd.op = OP_B3;   state_next = S_B4;  end
      S_B4:   begin cmd.op = OP_B4;   state_next = S_GAP; end
      S_GAP:  begin cmd.op = OP_GAP;  state_next = S_V0;  end
      S_V0:   begin cmd.op = OP_V0;   state_next = S_V1;  end
      S_V1:   begin cmd.op = OP_V1;   state_next = S_V2;  end
      S_V2:   begin cmd.op = OP_V2;   state_next = S_T0;  end
      S_T0:   begin cmd.op = OP_T0;   state_next = S_T1;  end
      S_T1:   begin cmd.op = OP_T1;   state_next = S_T2;  end
      S_T2:   begin cmd.op = OP_T2;   state_next = S_DONE; end
      S_DONE: begin
        // result register free or draining this cycle
        if (!out_valid || !out_stall) begin
          cmd.op     = OP_OUT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/wrsd_datapath.sv]
module wrsd_datapath #(
  parameter int SAMPLE_BITS    = 24,
  parameter int RATE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wrsd_pkg::dp_cmd_t               cmd,
  output wrsd_pkg::dp_status_t            st,
  input  logic                            cfg_we,
  input  logic [wrsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrsd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_cmd,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  input  logic [31:0]                     in_time_ms,
  output logic                            started,
  output logic                            rate_valid,
  output logic [31:0]                     raw_rate,
  output logic [31:0]                     ema_fast_out,
  output logic [31:0]                     ema_slow_out,
  output logic [31:0]                     gap,
  output logic [47:0]                     gap_variance,
  output logic [7:0]                      breach_count,
  output logic                            stop
);
  import wrsd_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int SUMW    = SB + 8;
  localparam int DVW_RAW = SB + RATE_FRAC_BITS + 4;
  localparam int DVW     = (DVW_RAW > 32) ? DVW_RAW : 33;
  localparam int HIW     = DVW - 32;

  // configuration
  logic [3:0]  avg_shift;
  logic [15:0] sample_interval_ms, alpha_fast, alpha_slow, beta_var, std_move;
  logic [7:0]  breach_limit;

  // detector state
  logic                   started_flag, averages_seeded, rate_valid_r;
  logic signed [SB-1:0]   tare_offset;
  logic [8:0]             sample_counter;
  logic signed [SUMW-1:0] sample_sum;
  logic signed [SB:0]     previous_net;
  logic [31:0]            last_update_time, fast_average, slow_average, latest_rate;
  logic [47:0]            variance_average;
  logic [7:0]             breach_counter;

  // working registers
  logic                   cmd_r;
  logic signed [SB-1:0]   smp_r, avg_r;
  logic [31:0]            now_r, dt_r, rem, quot;
  logic [HIW-1:0]         div_hi;
  logic [4:0]             div_cnt;
  logic [49:0]            tmp;
  logic [63:0]            prod, g2;
  logic [31:0]            std2;
  logic [55:0]            plo, phi;

  // combinational
  logic [3:0]             k;
  logic signed [SUMW-1:0] sum_new, avg_full;
  logic [8:0]             cnt_new;
  logic                   group_full, interval_ok;
  logic [31:0]            elapsed;
  logic signed [SB:0]     net;
  logic signed [SB+1:0]   d;
  logic [SB+1:0]          dw;
  logic [DVW-1:0]         dvd;
  logic [32:0]            trial;
  logic                   ge;
  logic [15:0]            mul_w;
  logic [47:0]            mul_x;
  logic [31:0]            slow_new, gap_w;
  logic [79:0]            thresh;
  logic                   breach;

  always_comb begin
    k          = (avg_shift > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : avg_shift;
    sum_new    = sample_sum + SUMW'(smp_r);
    cnt_new    = sample_counter + 9'd1;
    group_full = cnt_new >= (9'd1 << k);
    avg_full   = sum_new >>> k;
    elapsed    = now_r - last_update_time;
    interval_ok = elapsed >= {16'd0, sample_interval_ms};
    net   = (SB+1)'(avg_r) - (SB+1)'(tare_offset);
    d     = (SB+2)'(net) - (SB+2)'(previous_net);
    dw    = d[SB+1] ? (SB+2)'(-d) : (SB+2)'(d);
    dvd   = (DVW'(dw) * DVW'(RATE_MULT)) << (RATE_FRAC_BITS - WEIGHT_FRAC);
    trial = {rem, quot[31]};
    ge    = trial >= {1'b0, dt_r};
    slow_new = 32'(tmp - 50'(prod[63:16]));
    gap_w    = slow_average - fast_average;
    thresh   = 80'(plo) + (80'(phi) << 24);
    breach   = 80'(g2) > thresh;

    mul_w = alpha_fast;
    mul_x = 48'(latest_rate);
    case (cmd.op)
      OP_B1: begin mul_w = alpha_fast; mul_x = 48'(fast_average); end
      OP_B2: begin mul_w = alpha_slow; mul_x = 48'(latest_rate);  end
      OP_B3: begin mul_w = alpha_slow; mul_x = 48'(slow_average); end
      OP_V0: begin mul_w = beta_var;   mul_x = g2[63:16];         end
      OP_V1: begin mul_w = beta_var;   mul_x = variance_average;  end
      default: begin end
    endcase
  end

  assign st.rate_go  = !cmd_r && started_flag && interval_ok && group_full;
  assign st.seeded   = averages_seeded;
  assign st.sat      = 32'(div_hi) >= dt_r;
  assign st.div_last = (div_cnt == 5'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_shift          <= AVG_SHIFT_RESET;
      sample_interval_ms <= INTERVAL_RESET;
      alpha_fast         <= ALPHA_FAST_RESET;
      alpha_slow         <= ALPHA_SLOW_RESET;
      beta_var           <= BETA_VAR_RESET;
      std_move           <= STD_MOVE_RESET;
      breach_limit       <= BREACH_LIM_RESET;
      started_flag       <= 1'b0;
      averages_seeded    <= 1'b0;
      rate_valid_r       <= 1'b0;
      tare_offset        <= '0;
      sample_counter     <= '0;
      sample_sum         <= '0;
      previous_net       <= '0;
      last_update_time   <= '0;
      fast_average       <= '0;
      slow_average       <= '0;
      latest_rate        <= '0;
      variance_average   <= VAR_RESET;
      breach_counter     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_AVG_SHIFT:    avg_shift          <= cfg_data[3:0];
          REG_INTERVAL:     sample_interval_ms <= cfg_data;
          REG_ALPHA_FAST:   alpha_fast         <= cfg_data;
          REG_ALPHA_SLOW:   alpha_slow         <= cfg_data;
          REG_BETA_VAR:     beta_var           <= cfg_data;
          REG_STD_MOVE:     std_move           <= cfg_data;
          REG_BREACH_LIMIT: breach_limit       <= cfg_data[7:0];
          default: begin end
        endcase
      end
      case (cmd.op)
        OP_EVAL: begin
          rate_valid_r <= st.rate_go;
          if (cmd_r) begin
            started_flag     <= 1'b0;
            averages_seeded  <= 1'b0;
            tare_offset      <= '0;
            sample_counter   <= '0;
            sample_sum       <= '0;
            previous_net     <= '0;
            last_update_time <= '0;
            fast_average     <= '0;
            slow_average     <= '0;
            latest_rate      <= '0;
            variance_average <= VAR_RESET;
            breach_counter   <= '0;
          end else if (!started_flag || interval_ok) begin
            sample_sum     <= group_full ? '0 : sum_new;
            sample_counter <= group_full ? '0 : cnt_new;
            if (group_full && !started_flag) begin
              // first group average is the tare
              tare_offset      <= avg_full[SB-1:0];
              previous_net     <= '0;
              started_flag     <= 1'b1;
              last_update_time <= now_r;
            end
          end
        end
        OP_DIFF: begin
          previous_net     <= net;
          last_update_time <= now_r;
        end
        OP_DIVCHK: if (st.sat) latest_rate <= '1;
        OP_DIV:    if (st.div_last) latest_rate <= {quot[30:0], ge};
        OP_SEED: begin
          fast_average    <= latest_rate;
          slow_average    <= latest_rate;
          averages_seeded <= 1'b1;
        end
        OP_B2: fast_average <= 32'(tmp - 50'(prod[63:16]));
        OP_B4: begin
          slow_average <= slow_new;
          if (fast_average > slow_new) fast_average <= slow_new;
        end
        OP_V2: variance_average <= 48'(tmp - 50'(prod[63:16]));
        OP_T2: begin
          if (breach) begin
            if (breach_counter != 8'hFF) breach_counter <= breach_counter + 8'd1;
          end else begin
            breach_counter <= '0;
          end
        end
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_w) * 64'(mul_x);
    case (cmd.op)
      OP_LOAD: begin
        cmd_r <= in_cmd;
        smp_r <= in_sample;
        now_r <= in_time_ms;
      end
      OP_EVAL: avg_r <= avg_full[SB-1:0];
      OP_DIFF: begin
        div_hi <= dvd[DVW-1:32];
        quot   <= dvd[31:0];
        // zero elapsed time counts as one ms
        dt_r   <= (elapsed == 32'd0) ? 32'd1 : elapsed;
      end
      OP_DIVCHK: begin
        rem     <= 32'(div_hi);
        div_cnt <= '0;
      end
      OP_DIV: begin
        rem     <= ge ? 32'(trial - {1'b0, dt_r}) : trial[31:0];
        quot    <= {quot[30:0], ge};
        div_cnt <= div_cnt + 5'd1;
      end
      OP_B1: tmp <= 50'(fast_average) + 50'(prod[63:16]);
      OP_B3: tmp <= 50'(slow_average) + 50'(prod[63:16]);
      OP_GAP: begin
        g2   <= 64'(gap_w) * 64'(gap_w);
        std2 <= 32'(std_move) * 32'(std_move);
      end
      OP_V1: tmp <= 50'(variance_average) + 50'(prod[63:16]);
      OP_T0: plo <= 56'(std2) * 56'(variance_average[23:0]);
      OP_T1: phi <= 56'(std2) * 56'(variance_average[47:24]);
      OP_OUT: begin
        started      <= started_flag;
        rate_valid   <= rate_valid_r;
        raw_rate     <= latest_rate;
        ema_fast_out <= fast_average;
        ema_slow_out <= slow_average;
        gap          <= gap_w;
        gap_variance <= variance_average;
        breach_count <= breach_counter;
        stop         <= breach_counter >= breach_limit;
      end
      default: begin end
    endcase
  end

endmodule

[hw/rtl/weight_rate_stall_detector_core.sv]
// weight rate stall detector
// input channel: in_valid/in_stall with cmd, sample, time_ms. cmd high restarts
// detection and clears all tracking state; configuration registers are kept.
// output channel: out_valid/out_stall, exactly one result per input transfer.
// configuration: cfg_we writes cfg_data into register cfg_index (0..6). the
// user must write while the block is idle (not enforced); no read-back.
// steps: a sample that does not complete a rate update goes from evaluation
// to the output register. a sample that completes a group in tracking mode
// runs the rate update: difference, 32-step restoring divider (skipped when the
// rate saturates), five blend steps on a shared 16x48 multiplier (a seed step
// on the first update), gap square, three variance and three threshold steps.
// throughput: one item at a time, the next input transfer is taken once the
// result is in the output register, set by the serial divider and multiplier.
// reset: synchronous, restores register defaults and clears all tracking state.
// receiver stall: the output register holds its result; one finished result
// may wait there while the next item is being worked on.
module weight_rate_stall_detector_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int RATE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic [31:0]                     time_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            started,
  output logic                            rate_valid,
  output logic [31:0]                     raw_rate,
  output logic [31:0]                     ema_fast_out,
  output logic [31:0]                     ema_slow_out,
  output logic [31:0]                     gap,
  output logic [47:0]                     gap_variance,
  output logic [7:0]                      breach_count,
  output logic                            stop,
  input  logic                            cfg_we,
  input  logic [wrsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrsd_pkg::CFG_W-1:0]      cfg_data
);
  import wrsd_pkg::*;

  dp_cmd_t    dcmd;
  dp_status_t dst;

  wrsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (dst),
    .cmd       (dcmd)
  );

  wrsd_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dcmd),
    .st           (dst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_cmd       (cmd),
    .in_sample    (sample),
    .in_time_ms   (time_ms),
    .started      (started),
    .rate_valid   (rate_valid),
    .raw_rate     (raw_rate),
    .ema_fast_out (ema_fast_out),
    .ema_slow_out (ema_slow_out),
    .gap          (gap),
    .gap_variance (gap_variance),
    .breach_count (breach_count),
    .stop         (stop)
  );

endmodule

[hw/rtl/wrsd_checker.sv]
`include "weight_rate_stall_detector_core_defines.svh"

module wrsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        started,
  input logic        rate_valid,
  input logic [31:0] ema_fast_out,
  input logic [31:0] ema_slow_out,
  input logic [31:0] gap
);

  // fast average is clamped to the slow one
  `WRSD_ASSERT_IMPL(a_fast_le_slow, clk, rst, out_valid, ema_fast_out <= ema_slow_out)
  // reported gap matches the reported averages
  `WRSD_ASSERT_IMPL(a_gap_match, clk, rst, out_valid, gap == 32'(ema_slow_out - ema_fast_out))
  // a rate update only happens after the tare
  `WRSD_ASSERT_IMPL(a_rate_started, clk, rst, out_valid && rate_valid, started)
  // one item in work at a time
  `WRSD_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind weight_rate_stall_detector_core wrsd_checker u_wrsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .started      (started),
  .rate_valid   (rate_valid),
  .ema_fast_out (ema_fast_out),
  .ema_slow_out (ema_slow_out),
  .gap          (gap)
);

[tb/sv/weight_rate_stall_detector_core_chk.sv]
module weight_rate_stall_detector_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic signed [23:0] sample,
  input  logic [31:0] time_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        started,
  input  logic        rate_valid,
  input  logic [31:0] raw_rate,
  input  logic [31:0] ema_fast_out,
  input  logic [31:0] ema_slow_out,
  input  logic [31:0] gap,
  input  logic [47:0] gap_variance,
  input  logic [7:0]  breach_count,
  input  logic        stop,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          rate_updates,
  output int          max_breach,
  output int          stop_seen
);
  import wrsd_pkg::*;

  typedef struct {
    bit        started;
    bit        rate_valid;
    bit [31:0] raw_rate;
    bit [31:0] fast;
    bit [31:0] slow;
    bit [31:0] gap;
    bit [47:0] variance;
    bit [7:0]  breach;
    bit        stop;
  } detector_result_t;

  detector_result_t expected_results[$];

  // register copies
  bit [3:0]  r_shift;
  bit [15:0] r_interval, r_alpha_fast, r_alpha_slow, r_beta, r_std;
  bit [7:0]  r_limit;

  // tracking state
  bit        is_started, is_seeded;
  longint    tare, prev_net, group_sum;
  int        group_cnt;
  bit [31:0] last_time;
  bit [63:0] fast_avg, slow_avg, var_avg, last_rate;
  int        breach_cnt;

  function automatic bit [63:0] ema_step(bit [63:0] x, bit [63:0] r, bit [63:0] w);
    return x + ((w * r) >> 16) - ((w * x) >> 16);
  endfunction

  task automatic clear_tracking();
    is_started = 0;
    is_seeded  = 0;
    tare       = 0;
    prev_net   = 0;
    group_sum  = 0;
    group_cnt  = 0;
    last_time  = 0;
    fast_avg   = 0;
    slow_avg   = 0;
    var_avg    = 64'd32768;
    last_rate  = 0;
    breach_cnt = 0;
  endtask

  // adds one sample to the group, true with the floor average when full
  function automatic bit add_to_group(longint s, output longint avg);
    int k;
    k = (r_shift > MAX_SHIFT) ? MAX_SHIFT : r_shift;
    group_sum += s;
    group_cnt++;
    avg = 0;
    if (group_cnt < (1 << k)) return 0;
    avg = group_sum >>> k;
    group_sum = 0;
    group_cnt = 0;
    return 1;
  endfunction

  task automatic update_rate(longint avg, bit [31:0] now);
    longint    net, d;
    bit [63:0] dw, dt, rate, gp, g2, std2;
    bit [31:0] elapsed;
    bit        breach;
    net = avg - tare;
    d   = net - prev_net;
    dw  = (d < 0) ? -d : d;
    // elapsed time wraps at 32 bits
    elapsed = now - last_time;
    dt  = 64'(elapsed);
    if (dt == 0) dt = 1;
    rate = ((dw * 1000) << 8) / dt;
    if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
    last_rate = rate;
    if (!is_seeded) begin
      fast_avg  = rate;
      slow_avg  = rate;
      is_seeded = 1;
    end else begin
      fast_avg = ema_step(fast_avg, rate, r_alpha_fast);
      slow_avg = ema_step(slow_avg, rate, r_alpha_slow);
    end
    if (fast_avg > slow_avg) fast_avg = slow_avg;
    gp = slow_avg - fast_avg;
    g2 = gp * gp;
    var_avg = ema_step(var_avg, g2 >> 16, r_beta) & 64'hFFFF_FFFF_FFFF;
    std2 = r_std * r_std;
    if (std2 == 0 || var_avg == 0) breach = (g2 > 0);
    else if (var_avg > 64'hFFFF_FFFF_FFFF_FFFF / std2) breach = 0;
    else breach = (g2 > std2 * var_avg);
    if (breach) begin
      if (breach_cnt < 255) breach_cnt++;
    end else begin
      breach_cnt = 0;
    end
    prev_net  = net;
    last_time = now;
  endtask

  task automatic predict_item(bit c, longint s, bit [31:0] now);
    detector_result_t res;
    longint           avg;
    bit               upd;
    upd = 0;
    if (c) begin
      clear_tracking();
    end else if (!is_started) begin
      if (add_to_group(s, avg)) begin
        tare       = avg;
        prev_net   = 0;
        is_started = 1;
        last_time  = now;
      end
    end else if ((now - last_time) >= r_interval) begin
      if (add_to_group(s, avg)) begin
        update_rate(avg, now);
        upd = 1;
      end
    end
    res.started    = is_started;
    res.rate_valid = upd;
    res.raw_rate   = last_rate[31:0];
    res.fast       = fast_avg[31:0];
    res.slow       = slow_avg[31:0];
    res.gap        = 32'(slow_avg - fast_avg);
    res.variance   = var_avg[47:0];
    res.breach     = breach_cnt[7:0];
    res.stop       = (breach_cnt >= r_limit);
    expected_results.push_back(res);
  endtask

  task automatic report(string what, bit [63:0] got, bit [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    detector_result_t e;
    if (expected_results.size() == 0) begin
      $display("mismatch at %0t: result with nothing outstanding", $realtime);
      fail_count++;
      return;
    end
    e = expected_results.pop_front();
    if (started != e.started)         report("started", started, e.started);
    if (rate_valid != e.rate_valid)   report("rate_valid", rate_valid, e.rate_valid);
    if (raw_rate != e.raw_rate)       report("raw_rate", raw_rate, e.raw_rate);
    if (ema_fast_out != e.fast)       report("ema_fast_out", ema_fast_out, e.fast);
    if (ema_slow_out != e.slow)       report("ema_slow_out", ema_slow_out, e.slow);
    if (gap != e.gap)                 report("gap", gap, e.gap);
    if (gap_variance != e.variance)   report("gap_variance", gap_variance, e.variance);
    if (breach_count != e.breach)     report("breach_count", breach_count, e.breach);
    if (stop != e.stop)               report("stop", stop, e.stop);
    if (e.rate_valid) rate_updates++;
    if (e.breach > max_breach) max_breach = e.breach;
    if (e.stop) stop_seen++;
  endtask

  initial begin
    fail_count   = 0;
    pending      = 0;
    rate_updates = 0;
    max_breach   = 0;
    stop_seen    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      r_shift      = AVG_SHIFT_RESET;
      r_interval   = INTERVAL_RESET;
      r_alpha_fast = ALPHA_FAST_RESET;
      r_alpha_slow = ALPHA_SLOW_RESET;
      r_beta       = BETA_VAR_RESET;
      r_std        = STD_MOVE_RESET;
      r_limit      = BREACH_LIM_RESET;
      clear_tracking();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_AVG_SHIFT:    r_shift      = cfg_data[3:0];
          REG_INTERVAL:     r_interval   = cfg_data;
          REG_ALPHA_FAST:   r_alpha_fast = cfg_data;
          REG_ALPHA_SLOW:   r_alpha_slow = cfg_data;
          REG_BETA_VAR:     r_beta       = cfg_data;
          REG_STD_MOVE:     r_std        = cfg_data;
          REG_BREACH_LIMIT: r_limit      = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(cmd, longint'(sample), time_ms);
      if (out_valid && !out_stall) check_result();
    end
    pending = expected_results.size();
  end

endmodule

[tb/sv/weight_rate_stall_detector_core_tb.sv]
module weight_rate_stall_detector_core_tb;
  import wrsd_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        cmd = 0;
  logic signed [23:0] sample = 0;
  logic [31:0] time_ms = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        started, rate_valid, stop;
  logic [31:0] raw_rate, ema_fast_out, ema_slow_out, gap;
  logic [47:0] gap_variance;
  logic [7:0]  breach_count;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  int fail_count, pending, rate_updates, max_breach, stop_seen;
  int idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  bit hold_req = 0, hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  bit [31:0] now_ms = 0;
  int walk = 0;

  always #5 clk = ~clk;

  weight_rate_stall_detector_core u_top (.*);

  weight_rate_stall_detector_core_chk u_chk (.*);

  // receiver side, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= 300;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      case (idle_mode)
        2:       out_stall <= ($urandom_range(0, 99) < 48);
        3:       out_stall <= ($urandom_range(0, 99) < 30);
        default: out_stall <= 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(bit c, logic signed [23:0] s, bit [31:0] t);
    cmd      <= c;
    sample   <= s;
    time_ms  <= t;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if ((idle_mode == 1 && $urandom_range(0, 99) < 48) ||
        (idle_mode == 3 && $urandom_range(0, 99) < 30)) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(negedge clk); while (pending != 0);
    // a result may still be in flight behind the last one
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [15:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic setup(bit [3:0] sh, bit [15:0] iv, bit [15:0] af, bit [15:0] as_w,
                       bit [15:0] bv, bit [15:0] sm, bit [7:0] bl);
    drain();
    write_reg(REG_AVG_SHIFT, sh);
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_ALPHA_FAST, af);
    write_reg(REG_ALPHA_SLOW, as_w);
    write_reg(REG_BETA_VAR, bv);
    write_reg(REG_STD_MOVE, sm);
    write_reg(REG_BREACH_LIMIT, bl);
  endtask

  task automatic random_phase(int n, int iv, bit pressure);
    int r;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) hold_req <= !hold_req;
      r = $urandom_range(0, 99);
      if (r < 5) now_ms = $urandom;
      else now_ms += $urandom_range(0, iv + iv / 4 + 3);
      if ($urandom_range(0, 99) < 6) begin
        walk = $urandom_range(0, 4000) - 2000;
        send(1, 24'($urandom), $urandom);
      end else if ($urandom_range(0, 99) < 5) begin
        send(0, 24'($urandom), now_ms);
      end else begin
        walk += $urandom_range(0, 8000) - 4000;
        if (walk > 4000000 || walk < -4000000) walk = 0;
        send(0, 24'(walk + $urandom_range(0, 63)), now_ms);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, zero elapsed time, saturation, timestamp wrap, restart
    setup(0, 0, ALPHA_FAST_RESET, ALPHA_SLOW_RESET, BETA_VAR_RESET, STD_MOVE_RESET,
          BREACH_LIM_RESET);
    send(0, 24'sh7FFFFF, 0);
    send(0, -24'sh800000, 0);
    send(0, 0, 32'hFFFF_FFF0);
    send(0, 100, 5);
    send(1, 24'sh5A5A5A, 32'hA5A5_A5A5);
    send(0, -24'sh800000, 7);
    send(0, 24'sh7FFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) send(0, 24'(i * 37 - 150), 32'hFFFF_FFFF + i * 3);
    send(1, 0, 0);

    random_phase(150, 100, 0);  // averaging shift and interval are 0 from here, other registers at reset values
    setup(0, 10, 30000, 2000, 5000, 256, 3);
    idle_mode = 1;
    random_phase(250, 10, 1);
    setup(1, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 255);
    idle_mode = 2;
    random_phase(200, 0, 0);

    // saturated seed then small rates: gap stays open, count runs to full
    setup(0, 0, 16'hFFFF, 0, 0, 0, 255);
    idle_mode = 0;
    send(1, 0, 0);
    send(0, 0, 0);
    send(0, 24'sh7FFFFF, 1);
    for (int i = 0; i < 300; i++) send(0, 24'sh7FFFFF - (i % 50), 2 + i);

    setup(15, 16'hFFFF, 0, 16'hFFFF, 1, 1, 1);
    idle_mode = 3;
    random_phase(300, 65535, 0);
    setup(2, 50, 20000, 4000, 3000, 512, 2);
    random_phase(200, 50, 1);

    drain();
    $display("%0d items sent, %0d rate updates checked", items_sent, rate_updates);
    $display("highest breach count %0d, stop asserted on %0d results", max_breach,
             stop_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/wrsd_pkg.sv
hw/rtl/wrsd_ctrl.sv
hw/rtl/wrsd_datapath.sv
hw/rtl/weight_rate_stall_detector_core.sv
hw/rtl/wrsd_checker.sv
tb/sv/weight_rate_stall_detector_core_chk.sv
tb/sv/weight_rate_stall_detector_core_tb.sv
